### design/pcs_pkg.sv
// Package for the priority counter scheduler: sizes, command codes,
// transfer payload types and the refill divide-by-ten helper.
// Depends on nothing; used by priority_counter_scheduler.
`default_nettype none

package pcs_pkg;

  // Table sizes and field widths.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = 16;

  // Divide by ten through a reciprocal multiply; exact for 16-bit operands.
  localparam int              RECIP_SHIFT = 19;
  localparam logic [CNT_W:0]  RECIP_MUL   = 17'd52429;

  // Command codes of an input transfer.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic              command;
    logic [2:0]        slot;
    logic [15:0]       load_counter;
    logic [15:0]       load_priority;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        running_task;
    logic              switched;
    logic [15:0]       running_counter;
    logic              stuck;
  } out_item_t;

  // Quotient of a priority by ten.
  function automatic logic [CNT_W-1:0] div_ten(input logic [CNT_W-1:0] val);
    logic [2*CNT_W:0] prod;
    prod    = {{(CNT_W+1){1'b0}}, val} * {{CNT_W{1'b0}}, RECIP_MUL};
    div_ten = prod[RECIP_SHIFT +: CNT_W];
  endfunction

endpackage

`default_nettype wire

### design/priority_counter_scheduler.sv
// Priority counter scheduler top level: slot tables in synchronous memories,
// a sequencer for tick, scan and refill passes, and the result register.
// Depends on pcs_pkg.
//
// Usage: the input channel carries load and tick commands, the output channel
// one result per input transfer, both with valid and stall. A load to a slot
// other than the idle slot 0 writes its counter and priority and marks it
// present. A tick decrements the running task's counter and, when it reaches
// zero or idle is running, scans the present slots for the largest counter;
// an all-zero scan triggers a refill pass (counter/2 + priority/10) that also
// picks the new best slot. A load passes through the read-back state and a
// tick through the decrement state, then the scan and refill passes when
// needed, before its result reaches the result register; a tick taken while
// idle runs skips the decrement. The sequencer handles one item at a time and
// stalls the input until it is back in idle; the scan length is set by the
// single read port of the counter memory, one slot per cycle.
// Reset clears the present bits, the running slot (idle) and the sequencer;
// the memories need no clearing since only present slots' words are used.
// A stalled result stays in the output register; the next item is accepted
// meanwhile and waits for the register before its own result is written.
`default_nettype none

module priority_counter_scheduler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pcs_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pcs_pkg::out_item_t     out_item
);
  import pcs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DEC    = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_REFILL = 6'b001000,
    ST_RDOUT  = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [SLOT_W-1:0] IDLE_SLOT = '0;
  localparam logic [SLOT_W-1:0] LOW_SLOT  = SLOT_W'(1);

  // Slot tables.
  logic [CNT_W-1:0] cnt_mem [NUM_SLOTS];
  logic [CNT_W-1:0] pri_mem [NUM_SLOTS];
  logic [CNT_W-1:0] cnt_rd_r;
  logic [CNT_W-1:0] pri_rd_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              pri_we;

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic [NUM_SLOTS-1:0] present_r, present_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] before_r, before_nxt;
  logic [SLOT_W-1:0] iss_r, iss_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic [SLOT_W-1:0] evl_r, evl_nxt;
  logic              evl_on_r, evl_on_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              res_mem_r, res_mem_nxt;
  logic              res_stuck_r, res_stuck_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_acc;
  logic              load_ok;
  logic [CNT_W-1:0]  dec_val;
  logic [CNT_W:0]    refill_sum;
  logic [CNT_W-1:0]  refill_val;
  logic [CNT_W-1:0]  eval_val;
  logic              pass_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = (in_item.slot != IDLE_SLOT) && (32'(in_item.slot) < NUM_SLOTS);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Arithmetic on the word read from the tables.
  assign dec_val    = (cnt_rd_r == '0) ? '0 : cnt_rd_r - CNT_W'(1);
  assign refill_sum = {2'b00, cnt_rd_r[CNT_W-1:1]} + {1'b0, div_ten(pri_rd_r)};
  assign refill_val = refill_sum[CNT_W] ? '1 : refill_sum[CNT_W-1:0];
  assign eval_val   = (state_r == ST_REFILL) ? refill_val : cnt_rd_r;
  assign pass_done  = !iss_on_r && !evl_on_r;

  // Read address: the pass pointer during scans, otherwise the running slot.
  always_comb begin
    rd_addr = cur_r;
    if (state_r == ST_SCAN || state_r == ST_REFILL) begin
      rd_addr = iss_r;
    end
  end

  // Write port selection for the counter and priority tables.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = in_item.slot;
    cnt_wdata = in_item.load_counter;
    pri_we    = 1'b0;
    if (in_acc && in_item.command == CMD_LOAD && load_ok) begin
      cnt_we = 1'b1;
      pri_we = 1'b1;
    end else if (state_r == ST_DEC) begin
      cnt_we    = 1'b1;
      cnt_waddr = cur_r;
      cnt_wdata = dec_val;
    end else if (state_r == ST_REFILL && evl_on_r && present_r[evl_r]) begin
      cnt_we    = 1'b1;
      cnt_waddr = evl_r;
      cnt_wdata = refill_val;
    end
  end

  // Synchronous memories with a registered read port.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (pri_we) begin
      pri_mem[in_item.slot] <= in_item.load_priority;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
    pri_rd_r <= pri_mem[rd_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    cur_nxt       = cur_r;
    before_nxt    = before_r;
    iss_nxt       = iss_r;
    iss_on_nxt    = iss_on_r;
    evl_nxt       = evl_r;
    evl_on_nxt    = evl_on_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_cnt_nxt  = best_cnt_r;
    res_cnt_nxt   = res_cnt_r;
    res_mem_nxt   = res_mem_r;
    res_stuck_nxt = res_stuck_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          before_nxt    = cur_r;
          res_stuck_nxt = 1'b0;
          res_mem_nxt   = 1'b0;
          iss_nxt       = TOP_SLOT;
          iss_on_nxt    = 1'b1;
          evl_on_nxt    = 1'b0;
          found_nxt     = 1'b0;
          best_slot_nxt = IDLE_SLOT;
          best_cnt_nxt  = '0;
          if (in_item.command == CMD_LOAD) begin
            if (load_ok) begin
              present_nxt[in_item.slot] = 1'b1;
            end
            res_mem_nxt = 1'b1;
            state_nxt   = ST_RDOUT;
          end else if (cur_r == IDLE_SLOT) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DEC;
          end
        end
      end

      ST_DEC: begin
        // Running task loses one count; a zero count forces a reschedule.
        if (dec_val != '0) begin
          res_cnt_nxt = dec_val;
          state_nxt   = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN, ST_REFILL: begin
        // Issue one read per cycle from the top slot down to slot 1, evaluate it in the next cycle.
        evl_on_nxt = iss_on_r;
        if (iss_on_r) begin
          evl_nxt    = iss_r;
          iss_nxt    = iss_r - LOW_SLOT;
          iss_on_nxt = (iss_r != LOW_SLOT);
        end
        if (evl_on_r && present_r[evl_r] && (!found_r || eval_val > best_cnt_r)) begin
          found_nxt     = 1'b1;
          best_slot_nxt = evl_r;
          best_cnt_nxt  = eval_val;
        end
        if (pass_done) begin
          if (!found_r) begin
            cur_nxt     = IDLE_SLOT;
            res_cnt_nxt = '0;
            state_nxt   = ST_FIN;
          end else if (best_cnt_r != '0) begin
            cur_nxt     = best_slot_r;
            res_cnt_nxt = best_cnt_r;
            state_nxt   = ST_FIN;
          end else if (state_r == ST_SCAN) begin
            // Every present counter is zero: refill and choose again.
            iss_nxt    = TOP_SLOT;
            iss_on_nxt = 1'b1;
            evl_on_nxt = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = ST_REFILL;
          end else begin
            res_stuck_nxt = 1'b1;
            res_cnt_nxt   = '0;
            state_nxt     = ST_FIN;
          end
        end
      end

      ST_RDOUT: begin
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.running_task    = 3'(cur_r);
          out_item_nxt.switched        = (cur_r != before_r);
          out_item_nxt.running_counter = !res_mem_r ? 16'(res_cnt_r) :
                                         (cur_r == IDLE_SLOT) ? 16'd0 : 16'(cnt_rd_r);
          out_item_nxt.stuck           = res_stuck_r;
          state_nxt                    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      cur_r       <= IDLE_SLOT;
      iss_on_r    <= 1'b0;
      evl_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      cur_r       <= cur_nxt;
      iss_on_r    <= iss_on_nxt;
      evl_on_r    <= evl_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    before_r    <= before_nxt;
    iss_r       <= iss_nxt;
    evl_r       <= evl_nxt;
    found_r     <= found_nxt;
    best_slot_r <= best_slot_nxt;
    best_cnt_r  <= best_cnt_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_mem_r   <= res_mem_nxt;
    res_stuck_r <= res_stuck_nxt;
    out_item_r  <= out_item_nxt;
  end

  // The running slot is always idle or a present task.
  a_cur_present: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r == IDLE_SLOT) || present_r[cur_r])
    else $error("running slot is not present");

  // A stuck result reports a zero counter.
  a_stuck_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.stuck) |-> (out_item.running_counter == 16'd0))
    else $error("stuck result with nonzero counter");

  // A load transfer always goes through the read-back cycle.
  a_load_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.command == CMD_LOAD) |=> (state_r == ST_RDOUT))
    else $error("load did not enter read-back");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for priority_counter_scheduler: load and tick
// transfers with directed and random traffic, checked against an in-bench predictor.
// Depends on pcs_pkg and priority_counter_scheduler.
`default_nettype none

module tb;
  import pcs_pkg::*;

  // Clock, reset and the two transfer channels.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Idling rates in percent, and the receiver's long hold-off in cycles.
  int unsigned sender_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_goal      = 0;
  int unsigned hold_spent     = 0;

  // Predictor state: slot tables and the running slot.
  logic [CNT_W-1:0]  slot_count [NUM_SLOTS];
  logic [CNT_W-1:0]  slot_prio  [NUM_SLOTS];
  logic              slot_live  [NUM_SLOTS];
  logic [SLOT_W-1:0] running_slot;

  // Outcomes predicted for accepted commands, oldest first.
  out_item_t predicted_outcomes [$];

  int unsigned error_count  = 0;
  int unsigned tick_total   = 0;
  int unsigned load_total   = 0;
  int unsigned switch_total = 0;
  int unsigned stuck_total  = 0;

  priority_counter_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per problem and keeps the tally.
  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Largest counter among present real slots; ties go to the higher slot.
  function automatic logic find_largest(output int idx, output logic [CNT_W-1:0] cnt);
    logic found;
    found = 1'b0;
    idx   = 0;
    cnt   = '0;
    for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
      if (slot_live[i] && (!found || slot_count[i] > cnt)) begin
        found = 1'b1;
        idx   = i;
        cnt   = slot_count[i];
      end
    end
    return found;
  endfunction

  // Refill every present slot to half its counter plus a tenth of its priority.
  function automatic void refill_counters();
    logic [CNT_W:0] sum;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (slot_live[i]) begin
        sum = {1'b0, slot_count[i] >> 1} + {1'b0, slot_prio[i] / 16'd10};
        slot_count[i] = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
      end
    end
  endfunction

  // Chooses the next slot; returns 1 when a refill still leaves every counter at zero.
  function automatic logic pick_next_task();
    int               best;
    logic [CNT_W-1:0] best_cnt;
    if (!find_largest(best, best_cnt)) begin
      running_slot = '0;
      return 1'b0;
    end
    if (best_cnt == 0) begin
      refill_counters();
      void'(find_largest(best, best_cnt));
      if (best_cnt == 0)
        return 1'b1;
    end
    running_slot = best[SLOT_W-1:0];
    return 1'b0;
  endfunction

  // Applies one command to the predictor state and returns the outcome it causes.
  function automatic out_item_t predict_schedule(input in_item_t cmd);
    out_item_t         res;
    logic [SLOT_W-1:0] prev;
    logic              stuck_now;
    prev      = running_slot;
    stuck_now = 1'b0;
    if (cmd.command == CMD_LOAD) begin
      if (cmd.slot != 0 && int'(cmd.slot) < NUM_SLOTS) begin
        slot_count[cmd.slot] = cmd.load_counter;
        slot_prio[cmd.slot]  = cmd.load_priority;
        slot_live[cmd.slot]  = 1'b1;
      end
    end else if (running_slot == 0) begin
      stuck_now = pick_next_task();
    end else begin
      if (slot_count[running_slot] != 0)
        slot_count[running_slot] = slot_count[running_slot] - 1'b1;
      if (slot_count[running_slot] == 0)
        stuck_now = pick_next_task();
    end
    res.running_task    = running_slot;
    res.switched        = (running_slot != prev);
    res.running_counter = slot_count[running_slot];
    res.stuck           = stuck_now;
    return res;
  endfunction

  // Input monitor: every accepted transfer is run through the predictor.
  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_count[i] = '0;
        slot_prio[i]  = '0;
        slot_live[i]  = 1'b0;
      end
      running_slot = '0;
    end else if (in_valid && !in_stall) begin
      res = predict_schedule(in_item);
      predicted_outcomes.push_back(res);
      if (in_item.command == CMD_LOAD)
        load_total++;
      else
        tick_total++;
      if (res.switched)
        switch_total++;
      if (res.stuck)
        stuck_total++;
    end
  end

  // Result checker: each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (predicted_outcomes.size() == 0) begin
        flag_error($sformatf("result with nothing expected: %h", out_item));
      end else begin
        exp_res = predicted_outcomes.pop_front();
        if (out_item.running_task !== exp_res.running_task)
          flag_error($sformatf("running_task %h, expected %h",
                               out_item.running_task, exp_res.running_task));
        if (out_item.switched !== exp_res.switched)
          flag_error($sformatf("switched %b, expected %b",
                               out_item.switched, exp_res.switched));
        if (out_item.running_counter !== exp_res.running_counter)
          flag_error($sformatf("running_counter %h, expected %h",
                               out_item.running_counter, exp_res.running_counter));
        if (out_item.stuck !== exp_res.stuck)
          flag_error($sformatf("stuck %b, expected %b", out_item.stuck, exp_res.stuck));
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_spent < hold_goal) begin
      out_stall  <= 1'b1;
      hold_spent <= hold_spent + 1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Sends one command, with random gaps first, and returns once it has been accepted.
  task automatic send_command(input in_item_t cmd);
    logic [63:0] noise;
    while ($urandom_range(99) < sender_gap_pct) begin
      noise = {$urandom(), $urandom()};
      in_valid <= 1'b0;
      in_item  <= noise[$bits(in_item_t)-1:0];
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do
      @(posedge clk);
    while (in_stall !== 1'b0);
  endtask

  // Lowers valid and waits until every predicted outcome has arrived, then lets the
  // sequencer settle for longer than its slowest pass.
  task automatic wait_for_outcomes();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && predicted_outcomes.size() != 0; i++)
      @(posedge clk);
    if (predicted_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", predicted_outcomes.size()));
    repeat (4 * NUM_SLOTS + 8) @(posedge clk);
  endtask

  function automatic in_item_t load_cmd(input logic [2:0] slot, input logic [15:0] cnt,
                                        input logic [15:0] prio);
    in_item_t cmd;
    cmd.command       = CMD_LOAD;
    cmd.slot          = slot;
    cmd.load_counter  = cnt;
    cmd.load_priority = prio;
    return cmd;
  endfunction

  function automatic in_item_t tick_cmd();
    in_item_t cmd;
    cmd.command       = CMD_TICK;
    cmd.slot          = 3'($urandom());
    cmd.load_counter  = 16'($urandom());
    cmd.load_priority = 16'($urandom());
    return cmd;
  endfunction

  // Random command: mostly ticks and loads with small counters so that
  // reschedules and refills come often, plus some full-range values and
  // loads into the idle slot.
  function automatic in_item_t random_cmd();
    int unsigned pick;
    logic [15:0] cnt;
    logic [15:0] prio;
    pick = $urandom_range(99);
    if (pick < 3)
      return load_cmd(3'd0, 16'($urandom()), 16'($urandom()));
    if (pick >= 42)
      return tick_cmd();
    case ($urandom_range(9))
      0, 1:    cnt = '0;
      2, 3, 4: cnt = 16'($urandom_range(12));
      5, 6:    cnt = 16'($urandom_range(60));
      default: cnt = 16'($urandom());
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: prio = 16'($urandom_range(15));
      4, 5, 6:    prio = 16'($urandom_range(200));
      default:    prio = 16'($urandom());
    endcase
    return load_cmd(3'($urandom_range(NUM_SLOTS - 1, 1)), cnt, prio);
  endfunction

  // Idle behaviour, stuck refill, ties, loads into the running slot and the field extremes.
  task automatic test_directed_cases();
    send_command(tick_cmd());
    send_command(load_cmd(3'd0, 16'hFFFF, 16'hFFFF));
    send_command(tick_cmd());
    send_command(load_cmd(3'd3, 16'd0, 16'd5));
    send_command(tick_cmd());
    send_command(load_cmd(3'd5, 16'd3, 16'd0));
    send_command(load_cmd(3'd2, 16'd3, 16'd0));
    send_command(tick_cmd());
    send_command(tick_cmd());
    send_command(load_cmd(3'd5, 16'd0, 16'd20));
    send_command(tick_cmd());
    repeat (3) send_command(tick_cmd());
    send_command(load_cmd(3'd7, 16'hFFFF, 16'hFFFF));
    send_command(load_cmd(3'd1, 16'hFFFF, 16'd0));
    send_command(tick_cmd());
    send_command(tick_cmd());
    send_command(load_cmd(3'd7, 16'd1, 16'hFFFF));
    send_command(tick_cmd());
    send_command(load_cmd(3'd4, 16'h5555, 16'hAAAA));
    send_command(load_cmd(3'd6, 16'hAAAA, 16'h5555));
    send_command(tick_cmd());
    wait_for_outcomes();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_command(random_cmd());
    wait_for_outcomes();
  endtask

  // The receiver holds off while the sender keeps offering, so the block fills up.
  task automatic test_output_backpressure();
    hold_goal <= hold_goal + 400;
    repeat (30) send_command(random_cmd());
    wait_for_outcomes();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_gap_pct = 22;
    sink_stall_pct = 55;
    test_directed_cases();
    test_random_traffic(500, 22, 55);
    test_output_backpressure();
    test_random_traffic(500, 55, 22);
    test_random_traffic(500, 0, 0);
    $display("Covered %0d ticks and %0d loads over three idling patterns and one long hold-off;",
             tick_total, load_total);
    $display("%0d task switches and %0d stuck refills were seen.", switch_total, stuck_total);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", predicted_outcomes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
